// ===== design/rth_pkg.sv =====
// Shared types, constants and divider step function for the RGB to HSV pipeline.
package rth_pkg;

  // Scale constants of the conversion.
  localparam logic [7:0]  SCALE_MAX  = 8'd255;
  localparam logic [15:0] HUE_SPAN   = 16'd43;
  localparam logic [7:0]  GREEN_BASE = 8'd85;
  localparam logic [7:0]  BLUE_BASE  = 8'd170;

  // Number of divider stages, each retiring two quotient bits.
  localparam int unsigned DivStages = 4;

  // Hue sector picked by the largest channel.
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  // One input beat.
  typedef struct packed {
    logic [7:0] alpha_in;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  // Partial state of one long division: remainder, numerator bits still to
  // shift in, and the quotient built so far.
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] num;
    logic [7:0] quo;
  } div_t;

  // Payload carried between the pipeline stages.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] vmax;
    logic [7:0] chroma;
    sector_e    sector;
    logic       neg;
    div_t       sat_div;
    div_t       hue_div;
  } work_t;

  // One restoring division step: shift in the next numerator bit and
  // subtract the divisor when it fits. The remainder stays below the divisor.
  function automatic div_t div_bit(div_t d, logic [7:0] den);
    logic [8:0] trial;
    div_t       r;
    trial = {d.rem, d.num[7]};
    r     = d;
    r.num = {d.num[6:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      r.rem = 8'(trial - {1'b0, den});
      r.quo = {d.quo[6:0], 1'b1};
    end else begin
      r.rem = trial[7:0];
      r.quo = {d.quo[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== design/rgb_to_hsv_8bit_unit.sv =====
// Top level of the RGB to HSV pixel converter.
// Converts one 8-bit ARGB pixel per beat into alpha, hue, saturation and
// brightness, all on a 0..255 scale. The unit accepts one pixel every clock
// cycle while the output side is ready. Each result passes through one front
// stage (max, min, chroma, dividends), four divider stages that each retire
// two quotient bits of both divisions, and one output stage. Stalls on the
// output back up through the valid/ready chain without losing or repeating
// beats. Grey and black pixels give hue and saturation zero.
module rgb_to_hsv_8bit_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rth_pkg::pixel_t in_pixel_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rth_pkg::hsv_t   out_hsv_o
);
  import rth_pkg::*;

  logic  valid_s [DivStages+1];
  logic  ready_s [DivStages+1];
  work_t work_s  [DivStages+1];

  // Front stage.
  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_pixel_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .data_o  (work_s[0])
  );

  // Divider stages.
  for (genvar i = 0; i < DivStages; i++) begin : g_div
    rth_div_step u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .ready_o (ready_s[i]),
      .data_i  (work_s[i]),
      .valid_o (valid_s[i+1]),
      .ready_i (ready_s[i+1]),
      .data_o  (work_s[i+1])
    );
  end

  // Output stage.
  rth_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[DivStages]),
    .ready_o (ready_s[DivStages]),
    .data_i  (work_s[DivStages]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_hsv_o)
  );

`ifndef NO_ASSERTIONS
  // A grey or black pixel has no hue.
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_hsv_o.saturation == 8'd0 |-> out_hsv_o.hue == 8'd0)
    else $error("hue set on a grey pixel");

  // Black has no saturation.
  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_hsv_o.brightness == 8'd0 |-> out_hsv_o.saturation == 8'd0)
    else $error("saturation set on a black pixel");

  // With the last divider stage and the output stage both empty, no result
  // can show up in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && !valid_s[DivStages] |=> !out_valid_o)
    else $error("result appeared too early");
`endif

endmodule

// ===== design/rth_front.sv =====
// First stage: channel max and min, chroma, hue sector and the two dividends.
module rth_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rth_pkg::pixel_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rth_pkg::work_t  data_o
);
  import rth_pkg::*;

  logic              valid_q, valid_d;
  work_t             work_q, work_d;
  logic [7:0]        vmax, vmin;
  logic signed [8:0] diff;
  logic [7:0]        mag;
  logic [15:0]       sat_num, hue_num;
  logic              load;

  // Stage advances when empty or when the next stage takes its beat.
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Largest and smallest channel.
  always_comb begin
    vmax = data_i.red;
    vmin = data_i.red;
    if (data_i.green > vmax) vmax = data_i.green;
    if (data_i.blue > vmax)  vmax = data_i.blue;
    if (data_i.green < vmin) vmin = data_i.green;
    if (data_i.blue < vmin)  vmin = data_i.blue;
  end

  // Sector choice, red wins ties, then green; signed channel difference.
  always_comb begin
    work_d        = '0;
    work_d.alpha  = data_i.alpha_in;
    work_d.vmax   = vmax;
    work_d.chroma = vmax - vmin;
    if (vmax == data_i.red) begin
      work_d.sector = SECT_RED;
      diff = $signed({1'b0, data_i.green}) - $signed({1'b0, data_i.blue});
    end else if (vmax == data_i.green) begin
      work_d.sector = SECT_GREEN;
      diff = $signed({1'b0, data_i.blue}) - $signed({1'b0, data_i.red});
    end else begin
      work_d.sector = SECT_BLUE;
      diff = $signed({1'b0, data_i.red}) - $signed({1'b0, data_i.green});
    end
    work_d.neg = diff[8];
    mag        = diff[8] ? 8'(-diff) : diff[7:0];

    // Dividends 255*chroma and 43*|diff|; both quotients fit in eight bits,
    // so the upper byte already sits below the divisor.
    sat_num = {work_d.chroma, 8'd0} - {8'd0, work_d.chroma};
    hue_num = 16'({8'd0, mag} * HUE_SPAN);

    work_d.sat_div.rem = sat_num[15:8];
    work_d.sat_div.num = sat_num[7:0];
    work_d.sat_div.quo = '0;
    work_d.hue_div.rem = hue_num[15:8];
    work_d.hue_div.num = hue_num[7:0];
    work_d.hue_div.quo = '0;
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = work_q;

endmodule

// ===== design/rth_div_step.sv =====
// Divider stage: two quotient bits of both the saturation and hue divisions.
module rth_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rth_pkg::work_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rth_pkg::work_t data_o
);
  import rth_pkg::*;

  logic  valid_q, valid_d;
  work_t work_q, work_d;
  logic  load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Two restoring steps per division; saturation divides by value, hue by chroma.
  always_comb begin
    work_d         = data_i;
    work_d.sat_div = div_bit(div_bit(data_i.sat_div, data_i.vmax), data_i.vmax);
    work_d.hue_div = div_bit(div_bit(data_i.hue_div, data_i.chroma), data_i.chroma);
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = work_q;

`ifndef NO_ASSERTIONS
  // The saturation remainder stays below a nonzero value.
  a_sat_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && work_q.vmax != 8'd0 |-> work_q.sat_div.rem < work_q.vmax)
    else $error("saturation remainder not below divisor");

  // The hue remainder stays below a nonzero chroma.
  a_hue_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && work_q.chroma != 8'd0 |-> work_q.hue_div.rem < work_q.chroma)
    else $error("hue remainder not below divisor");

  // Chroma never exceeds the value it came from.
  a_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> work_q.chroma <= work_q.vmax)
    else $error("chroma above value");
`endif

endmodule

// ===== design/rth_back.sv =====
// Last stage: hue offset by sector, sign handling, grey case, output register.
module rth_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rth_pkg::work_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rth_pkg::hsv_t  data_o
);
  import rth_pkg::*;

  logic       valid_q, valid_d;
  hsv_t       hsv_q, hsv_d;
  logic [7:0] q;
  logic       load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign q       = data_i.hue_div.quo;

  // Quotient of 43*diff/chroma truncates toward zero, so the sign is applied
  // to the magnitude quotient. A negative red hue wraps by adding 255.
  // A black pixel divides by zero value, so its saturation is forced to zero.
  always_comb begin
    hsv_d.alpha_out  = data_i.alpha;
    hsv_d.brightness = data_i.vmax;
    hsv_d.saturation = (data_i.vmax != 8'd0) ? data_i.sat_div.quo : 8'd0;
    hsv_d.hue        = '0;
    if (data_i.chroma != 8'd0) begin
      case (data_i.sector)
        SECT_RED: begin
          hsv_d.hue = (data_i.neg && q != 8'd0) ? SCALE_MAX - q : q;
        end
        SECT_GREEN: begin
          hsv_d.hue = data_i.neg ? GREEN_BASE - q : GREEN_BASE + q;
        end
        SECT_BLUE: begin
          hsv_d.hue = data_i.neg ? BLUE_BASE - q : BLUE_BASE + q;
        end
        default: begin
          hsv_d.hue = '0;
        end
      endcase
    end
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hsv_q <= hsv_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = hsv_q;

endmodule

// ===== sim/tb_rgb_to_hsv_8bit_unit.sv =====
// Self-checking testbench for the RGB to HSV pixel converter.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_8bit_unit;
  import rth_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned LongHold = 300;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  pixel_t in_pixel_i;
  logic   out_valid_o;
  logic   out_ready_i;
  hsv_t   out_hsv_o;

  // Expected HSV beats, oldest first.
  hsv_t        expected_hsv_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Idle controls shared by the test tasks and the output side.
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          long_hold_req = 1'b0;

  rgb_to_hsv_8bit_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_hsv_o   (out_hsv_o)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Computes the HSV beat that one pixel must produce.
  function automatic hsv_t convert_pixel(pixel_t px);
    int   r, g, b;
    int   vmax, vmin, chroma, h, s;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    vmax = r;
    vmin = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    h = 0;
    s = 0;
    if (vmax != 0) begin
      chroma = vmax - vmin;
      s = (int'(SCALE_MAX) * chroma) / vmax;
      // Signed division in SystemVerilog truncates toward zero.
      if (s != 0) begin
        if (vmax == r) begin
          h = (int'(HUE_SPAN) * (g - b)) / chroma;
          if (h < 0) h += int'(SCALE_MAX);
        end else if (vmax == g) begin
          h = int'(GREEN_BASE) + (int'(HUE_SPAN) * (b - r)) / chroma;
        end else begin
          h = int'(BLUE_BASE) + (int'(HUE_SPAN) * (r - g)) / chroma;
        end
      end
    end
    res.alpha_out  = px.alpha_in;
    res.hue        = 8'(h);
    res.saturation = 8'(s);
    res.brightness = 8'(vmax);
    return res;
  endfunction

  // Random pixel, biased toward greys, ties and small chroma.
  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned pick;
    int unsigned base;
    px = pixel_t'($urandom);
    pick = $urandom_range(0, 99);
    base = $urandom_range(0, 255);
    if (pick < 10) begin
      px.red   = 8'(base);
      px.green = 8'(base);
      px.blue  = 8'(base);
    end else if (pick < 25) begin
      // Two channels tie; the third is random.
      case ($urandom_range(0, 2))
        0: px.green = px.red;
        1: px.blue  = px.red;
        default: px.blue = px.green;
      endcase
    end else if (pick < 40) begin
      px.red   = 8'(base);
      px.green = 8'(base > 3 ? base - $urandom_range(0, 3) : base);
      px.blue  = 8'(base > 3 ? base - $urandom_range(0, 3) : base);
    end
    return px;
  endfunction

  // Offers one pixel beat and returns once it has been accepted. Valid is
  // only lowered when a gap follows, so back-to-back beats keep it high.
  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_rgb(input int a, input int r, input int g, input int b);
    send_pixel(pixel_t'({8'(a), 8'(r), 8'(g), 8'(b)}));
  endtask

  // Black, white, greys, pure colors, ties and both signs in every sector.
  task automatic test_corner_pixels();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_rgb(0, 0, 0, 0);
    send_rgb(255, 255, 255, 255);
    send_rgb(128, 1, 1, 1);
    send_rgb(1, 1, 0, 0);
    send_rgb(255, 255, 0, 0);
    send_rgb(170, 0, 255, 0);
    send_rgb(85, 0, 0, 255);
    send_rgb(0, 255, 255, 0);
    send_rgb(0, 0, 255, 255);
    send_rgb(0, 255, 0, 255);
    send_rgb(255, 255, 0, 1);
    send_rgb(255, 255, 1, 0);
    send_rgb(7, 200, 10, 90);
    send_rgb(7, 10, 200, 90);
    send_rgb(7, 90, 200, 10);
    send_rgb(7, 10, 90, 200);
    send_rgb(7, 90, 10, 200);
    send_rgb(3, 255, 254, 254);
    send_rgb(3, 2, 1, 1);
    send_rgb(255, 0, 128, 255);
  endtask

  // Random pixels with random gaps on both sides.
  task automatic test_random_idle(input int unsigned count);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (count) send_pixel(random_pixel());
  endtask

  // Random pixels at full rate on both sides.
  task automatic test_full_rate(input int unsigned count);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (count) send_pixel(random_pixel());
  endtask

  // The output side holds off for a long stretch while pixels keep coming,
  // so the pipeline fills and stalls its input.
  task automatic test_output_stall(input int unsigned count);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    long_hold_req = 1'b1;
    repeat (count) send_pixel(random_pixel());
  endtask

  // Output side: per result beat, a random or long hold-off when enabled, then ready until taken.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_idle ? $urandom_range(0, 17) : 0;
      if (long_hold_req) begin
        gap = LongHold;
        long_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Records each accepted pixel and checks each accepted HSV beat.
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_hsv_q.push_back(convert_pixel(in_pixel_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_hsv_q.size() == 0) begin
          $error("unexpected result beat: %h", out_hsv_o);
          mismatch_count++;
        end else begin
          want = expected_hsv_q.pop_front();
          if (out_hsv_o.alpha_out !== want.alpha_out) begin
            $error("alpha_out: expected %0d, actual %0d", want.alpha_out,
                   out_hsv_o.alpha_out);
            mismatch_count++;
          end
          if (out_hsv_o.hue !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, out_hsv_o.hue);
            mismatch_count++;
          end
          if (out_hsv_o.saturation !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation,
                   out_hsv_o.saturation);
            mismatch_count++;
          end
          if (out_hsv_o.brightness !== want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness,
                   out_hsv_o.brightness);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Reset, the test sequence, drain and verdict.
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_pixel_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_random_idle(250);
    test_full_rate(120);
    test_output_stall(80);
    test_random_idle(100);

    in_valid_i <= 1'b0;
    while (expected_hsv_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
